// ===== hdl/lwbc_pkg.sv =====
// Shared codes and types for the LRU write-back cache core.
package lwbc_pkg;

	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 4;
	localparam int STAMP_W = 32;

	localparam logic [OP_W-1:0] OP_GET   = 2'd0;
	localparam logic [OP_W-1:0] OP_SET   = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_WB    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_ACT,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_FL_RD,
		ST_FL_CHK,
		ST_OUT_A,
		ST_OUT_B
	} state_t;

endpackage

// ===== hdl/lwbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lwbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lru_write_back_cache_core.sv =====
// Fully associative write-back cache with exact LRU in front of a backing store.
// All entries (tag, dirty mark, access stamp, data) live in one RAM with a
// registered read; per-entry valid flops make unwritten entries read as empty.
// Requests are served one at a time. A get or set reads every slot below capacity
// once, rereads the chosen slot, writes it back, then sends its one or two results;
// with key zero or capacity zero it skips the scan and goes to the backing store.
// A fill rereads its claimed slot, writes it if still claimed, clean and in range,
// then sends its result. A flush reads each slot below capacity in turn, each
// write-back leaving as its slot is checked. The single RAM read port reads one slot at a time.
// Results leave through an output register so the sequencer keeps going while a
// result waits. Capacity must be written only when idle: the block does not enforce it.
module lru_write_back_cache_core import lwbc_pkg::*; #(
	parameter int ENTRIES    = 8,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	localparam int DATA_W    = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // key, value
	input  logic [OP_W-1:0]   s_tuser,   // op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // out_key, out_value
	output logic [KIND_W-1:0] m_tuser,   // kind
	output logic              m_tlast
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int E_W   = KEY_BITS + 1 + STAMP_W + VALUE_BITS;

	state_t state_q, state_d;

	logic [CW-1:0]         capacity_q;
	logic [CNT_W-1:0]      cap;

	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      idx_nxt;

	logic                  scan_vld_s1;
	logic [IDX_W-1:0]      raddr_s1;
	logic                  hit_q, empty_q;
	logic [IDX_W-1:0]      hit_idx_q, empty_idx_q, best_idx_q, slot_q, chosen;
	logic [STAMP_W-1:0]    best_stamp_q;

	logic [ENTRIES-1:0]    valid_q;
	logic [STAMP_W-1:0]    use_cnt_q;
	logic                  pend_fill_q;
	logic [KEY_BITS-1:0]   pend_key_q;
	logic [IDX_W-1:0]      pend_slot_q;

	logic [KIND_W-1:0]     a_kind_q, b_kind_q;
	logic [KEY_BITS-1:0]   a_key_q, b_key_q;
	logic [VALUE_BITS-1:0] a_val_q, b_val_q;
	logic                  a_last_q;

	logic                  m_tvalid_q, out_last_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [KEY_BITS-1:0]   out_key_q;
	logic [VALUE_BITS-1:0] out_val_q;

	logic                  out_load, out_last_d, out_free;
	logic [KIND_W-1:0]     out_kind_d;
	logic [KEY_BITS-1:0]   out_key_d;
	logic [VALUE_BITS-1:0] out_val_d;

	logic                  ram_re, ram_we;
	logic [IDX_W-1:0]      ram_raddr, ram_waddr;
	logic [E_W-1:0]        ram_wdata, ram_rdata;

	logic                  rd_ok, rd_dirty;
	logic [KEY_BITS-1:0]   rd_tag;
	logic [STAMP_W-1:0]    rd_stamp;
	logic [VALUE_BITS-1:0] rd_data;

	logic [KEY_BITS-1:0]   s_key;
	logic [VALUE_BITS-1:0] s_val;
	logic                  accept, pass, fill_ok, fl_need, victim_wb, new_dirty;
	logic [VALUE_BITS-1:0] new_data;
	logic [STAMP_W-1:0]    new_stamp;

	assign cap = (capacity_q > CW'(ENTRIES)) ? CNT_W'(ENTRIES) : capacity_q[CNT_W-1:0];

	assign s_key  = s_tdata[KEY_BITS-1:0];
	assign s_val  = s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
	assign accept = s_tvalid && s_tready;
	assign pass   = (cap == '0) || (s_key == '0);

	assign idx_nxt  = idx_q + 1'b1;
	assign out_free = !m_tvalid_q || m_tready;

	// Unwritten entries read as empty, clean and stamp zero.
	assign rd_ok    = valid_q[raddr_s1];
	assign rd_tag   = rd_ok ? ram_rdata[KEY_BITS-1:0] : '0;
	assign rd_dirty = rd_ok && ram_rdata[KEY_BITS];
	assign rd_stamp = rd_ok ? ram_rdata[KEY_BITS+STAMP_W:KEY_BITS+1] : '0;
	assign rd_data  = ram_rdata[E_W-1:E_W-VALUE_BITS];

	assign chosen    = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : best_idx_q);
	assign victim_wb = !hit_q && (rd_tag != '0) && rd_dirty;
	assign fill_ok   = pend_fill_q && (CNT_W'(pend_slot_q) < cap) &&
	                   (rd_tag == pend_key_q) && !rd_dirty;
	assign fl_need   = (rd_tag != '0) && rd_dirty;
	assign new_stamp = use_cnt_q + 1'b1;
	assign new_dirty = (op_q == OP_SET) || (hit_q && rd_dirty);
	assign new_data  = (op_q == OP_SET) ? val_q : rd_data;

	lwbc_ram #(
		.WIDTH (E_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						OP_GET, OP_SET: state_d = pass ? ST_OUT_A : ST_SCAN;
						OP_FILL:        state_d = ST_FILL_RD;
						default:        state_d = (cap == '0) ? ST_OUT_A : ST_FL_RD;
					endcase
				end
			end
			ST_SCAN: begin
				if (idx_q == cap && !scan_vld_s1) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK:    state_d = ST_ACT;
			ST_ACT:     state_d = ST_OUT_A;
			ST_FILL_RD: state_d = ST_FILL_WR;
			ST_FILL_WR: state_d = ST_OUT_A;
			ST_FL_RD:   state_d = ST_FL_CHK;
			ST_FL_CHK: begin
				if (!fl_need || out_free) begin
					state_d = (idx_nxt == cap) ? ST_OUT_A : ST_FL_RD;
				end
			end
			ST_OUT_A: begin
				if (out_free) begin
					state_d = a_last_q ? ST_IDLE : ST_OUT_B;
				end
			end
			ST_OUT_B: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control and result loading.
	always_comb begin
		s_tready   = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = idx_q[IDX_W-1:0];
		ram_we     = 1'b0;
		ram_waddr  = slot_q;
		ram_wdata  = {new_data, new_stamp, new_dirty, key_q};
		out_load   = 1'b0;
		out_kind_d = a_kind_q;
		out_key_d  = a_key_q;
		out_val_d  = a_val_q;
		out_last_d = a_last_q;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: ram_re = (idx_q < cap);
			ST_PICK: begin
				ram_re    = 1'b1;
				ram_raddr = chosen;
			end
			ST_ACT: ram_we = 1'b1;
			ST_FILL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = pend_slot_q;
			end
			ST_FILL_WR: begin
				ram_we    = fill_ok;
				ram_waddr = pend_slot_q;
				ram_wdata = {val_q, rd_stamp, rd_dirty, rd_tag};
			end
			ST_FL_RD: ram_re = 1'b1;
			ST_FL_CHK: begin
				out_load   = fl_need && out_free;
				out_kind_d = KIND_WB;
				out_key_d  = rd_tag;
				out_val_d  = rd_data;
				out_last_d = 1'b0;
			end
			ST_OUT_A: out_load = out_free;
			ST_OUT_B: begin
				out_load   = out_free;
				out_kind_d = b_kind_q;
				out_key_d  = b_key_q;
				out_val_d  = b_val_q;
				out_last_d = 1'b1;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CW'(ENTRIES);
			valid_q     <= '0;
			use_cnt_q   <= '0;
			pend_fill_q <= 1'b0;
			pend_key_q  <= '0;
			pend_slot_q <= '0;
			scan_vld_s1 <= 1'b0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				capacity_q <= CW'(cfg_wdata);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					scan_vld_s1 <= 1'b0;
					hit_q       <= 1'b0;
					empty_q     <= 1'b0;
					if (accept && s_tuser == OP_GET && pass) begin
						pend_fill_q <= 1'b1;
						pend_key_q  <= s_key;
						pend_slot_q <= '0;
					end
				end
				ST_SCAN: begin
					scan_vld_s1 <= ram_re;
					if (scan_vld_s1) begin
						if (!hit_q && rd_tag == key_q) begin
							hit_q <= 1'b1;
						end
						if (!empty_q && rd_tag == '0) begin
							empty_q <= 1'b1;
						end
					end
				end
				ST_ACT: begin
					valid_q[slot_q] <= 1'b1;
					use_cnt_q       <= new_stamp;
					if (op_q == OP_GET && !hit_q) begin
						pend_fill_q <= 1'b1;
						pend_key_q  <= key_q;
						pend_slot_q <= slot_q;
					end
				end
				ST_FILL_WR: begin
					pend_fill_q <= 1'b0;
					if (fill_ok) begin
						valid_q[pend_slot_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Request, scan and result payload.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			raddr_s1 <= ram_raddr;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_key_q  <= out_key_d;
			out_val_q  <= out_val_d;
			out_last_q <= out_last_d;
		end
		case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
				if (accept) begin
					op_q  <= s_tuser;
					key_q <= s_key;
					val_q <= s_val;
					b_kind_q <= KIND_DONE;
					b_key_q  <= '0;
					b_val_q  <= '0;
					case (s_tuser)
						OP_GET: begin
							a_kind_q <= KIND_FETCH;
							a_key_q  <= s_key;
							a_val_q  <= '0;
							a_last_q <= 1'b1;
						end
						OP_SET: begin
							a_kind_q <= KIND_WB;
							a_key_q  <= s_key;
							a_val_q  <= s_val;
							a_last_q <= 1'b0;
						end
						OP_FILL: begin
							a_kind_q <= KIND_READ;
							a_key_q  <= '0;
							a_val_q  <= s_val;
							a_last_q <= 1'b1;
						end
						default: begin
							a_kind_q <= KIND_DONE;
							a_key_q  <= '0;
							a_val_q  <= '0;
							a_last_q <= 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (ram_re) begin
					idx_q <= idx_nxt;
				end
				if (scan_vld_s1) begin
					if (!hit_q && rd_tag == key_q) begin
						hit_idx_q <= raddr_s1;
					end
					if (!empty_q && rd_tag == '0) begin
						empty_idx_q <= raddr_s1;
					end
					// Strict compare keeps the lowest index on equal stamps.
					if (raddr_s1 == '0 || rd_stamp < best_stamp_q) begin
						best_idx_q   <= raddr_s1;
						best_stamp_q <= rd_stamp;
					end
				end
			end
			ST_PICK: slot_q <= chosen;
			ST_ACT: begin
				b_kind_q <= KIND_WB;
				b_key_q  <= rd_tag;
				b_val_q  <= rd_data;
				if (op_q == OP_GET) begin
					if (hit_q) begin
						a_kind_q <= KIND_READ;
						a_key_q  <= '0;
						a_val_q  <= rd_data;
						a_last_q <= 1'b1;
					end else begin
						a_kind_q <= KIND_FETCH;
						a_key_q  <= key_q;
						a_val_q  <= '0;
						a_last_q <= !victim_wb;
					end
				end else if (victim_wb) begin
					a_kind_q <= KIND_WB;
					a_key_q  <= rd_tag;
					a_val_q  <= rd_data;
					a_last_q <= 1'b0;
					b_kind_q <= KIND_DONE;
					b_key_q  <= '0;
					b_val_q  <= '0;
				end else begin
					a_kind_q <= KIND_DONE;
					a_key_q  <= '0;
					a_val_q  <= '0;
					a_last_q <= 1'b1;
				end
			end
			ST_FL_CHK: begin
				if (!fl_need || out_free) begin
					idx_q <= idx_nxt;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = DATA_W'({out_val_q, out_key_q});

	// The scan never reads at or beyond the active capacity.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ram_re) |-> (idx_q < cap))
		else $error("scan read beyond capacity");

	// The use counter moves only on the slot write of a get or set.
	a_counter_only_on_act: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACT) |=> $stable(use_cnt_q))
		else $error("use counter changed outside slot update");

	// A get miss leaves a pending fill on a valid claimed slot.
	a_miss_arms_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACT && op_q == OP_GET && !hit_q)
		|=> (pend_fill_q && pend_slot_q == slot_q && valid_q[slot_q]))
		else $error("get miss did not arm pending fill");

	// Loading the final result of a request returns the sequencer to idle.
	a_last_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == ST_IDLE))
		else $error("final result loaded but request not finished");

endmodule

// ===== tb/lru_write_back_cache_core_tb.sv =====
// Testbench for the LRU write-back cache core: directed and random traffic checked against a cache predictor.
module lru_write_back_cache_core_tb import lwbc_pkg::*; ();

	localparam int DATA_W      = 64;
	localparam int CACHE_SLOTS = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [31:0]     key;
		logic [31:0]     value;
	} cache_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [31:0]       key;
		logic [31:0]       value;
		logic              last;
	} cache_rsp_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;    // key, value
	logic [OP_W-1:0]   s_tuser = '0;    // op
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // out_key, out_value
	logic [KIND_W-1:0] m_tuser;         // kind
	logic              m_tlast;

	// cache shadow state
	logic [31:0]      tag_mem [CACHE_SLOTS];
	logic [31:0]      data_mem [CACHE_SLOTS];
	logic [31:0]      stamp_mem [CACHE_SLOTS];
	bit               dirty_mem [CACHE_SLOTS];
	bit               written_mem [CACHE_SLOTS];
	logic [31:0]      use_count = '0;
	bit               fill_armed = 1'b0;
	logic [31:0]      fill_key = '0;
	int               fill_slot = 0;
	logic [CFG_W-1:0] capacity_reg = CFG_W'(CACHE_SLOTS);

	cache_req_t pending_requests[$];
	cache_rsp_t expected_responses[$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int offered_count = 0;
	int taken_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	bit stall_request = 1'b0;
	bit stall_served = 1'b0;

	lru_write_back_cache_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			tag_mem[i] = '0;
			data_mem[i] = '0;
			stamp_mem[i] = '0;
			dirty_mem[i] = 1'b0;
			written_mem[i] = 1'b0;
		end
	end

	function automatic int active_slots();
		return (capacity_reg > CACHE_SLOTS) ? CACHE_SLOTS : int'(capacity_reg);
	endfunction

	// Matching slot, else first empty slot, else least recently used (lowest index on ties).
	function automatic int pick_slot(input logic [31:0] key, input int active, output bit hit);
		int best;
		hit = 1'b0;
		best = 0;
		for (int i = 0; i < active; i++)
			if (tag_mem[i] == key) begin
				hit = 1'b1;
				return i;
			end
		for (int i = 0; i < active; i++)
			if (tag_mem[i] == 0)
				return i;
		for (int i = 1; i < active; i++)
			if (stamp_mem[i] < stamp_mem[best])
				best = i;
		return best;
	endfunction

	// A get hit on a claimed slot whose data never arrived must not be issued.
	function automatic bit reads_unwritten(input logic [OP_W-1:0] op, input logic [31:0] key);
		int active, slot;
		bit hit;
		active = active_slots();
		if (op != OP_GET || key == 0 || active == 0)
			return 1'b0;
		slot = pick_slot(key, active, hit);
		return hit && !written_mem[slot];
	endfunction

	task automatic push_response(input logic [KIND_W-1:0] kind, input logic [31:0] key,
			input logic [31:0] value, input logic last);
		cache_rsp_t rsp;
		rsp.kind = kind;
		rsp.key = key;
		rsp.value = value;
		rsp.last = last;
		expected_responses.push_back(rsp);
	endtask

	task automatic cache_access(input logic [OP_W-1:0] op, input logic [31:0] key,
			input logic [31:0] value);
		int active, slot;
		bit hit, victim_wb;
		active = active_slots();
		case (op)
		OP_GET: begin
			if (active == 0 || key == 0) begin
				push_response(KIND_FETCH, key, '0, 1'b1);
				fill_armed = 1'b1;
				fill_key = key;
				fill_slot = 0;
			end else begin
				slot = pick_slot(key, active, hit);
				if (hit) begin
					push_response(KIND_READ, '0, data_mem[slot], 1'b1);
				end else begin
					victim_wb = tag_mem[slot] != 0 && dirty_mem[slot];
					push_response(KIND_FETCH, key, '0, !victim_wb);
					if (victim_wb)
						push_response(KIND_WB, tag_mem[slot], data_mem[slot], 1'b1);
					tag_mem[slot] = key;
					dirty_mem[slot] = 1'b0;
					fill_armed = 1'b1;
					fill_key = key;
					fill_slot = slot;
				end
				use_count = use_count + 1;
				stamp_mem[slot] = use_count;
			end
		end
		OP_SET: begin
			if (active == 0 || key == 0) begin
				push_response(KIND_WB, key, value, 1'b0);
			end else begin
				slot = pick_slot(key, active, hit);
				if (!hit && tag_mem[slot] != 0 && dirty_mem[slot])
					push_response(KIND_WB, tag_mem[slot], data_mem[slot], 1'b0);
				tag_mem[slot] = key;
				data_mem[slot] = value;
				written_mem[slot] = 1'b1;
				dirty_mem[slot] = 1'b1;
				use_count = use_count + 1;
				stamp_mem[slot] = use_count;
			end
			push_response(KIND_DONE, '0, '0, 1'b1);
		end
		OP_FILL: begin
			// install only if the claimed slot still holds the key, clean
			if (fill_armed && fill_slot < active && tag_mem[fill_slot] == fill_key &&
					!dirty_mem[fill_slot]) begin
				data_mem[fill_slot] = value;
				written_mem[fill_slot] = 1'b1;
			end
			fill_armed = 1'b0;
			push_response(KIND_READ, '0, value, 1'b1);
		end
		default: begin
			for (int i = 0; i < active; i++)
				if (tag_mem[i] != 0 && dirty_mem[i])
					push_response(KIND_WB, tag_mem[i], data_mem[i], 1'b0);
			push_response(KIND_DONE, '0, '0, 1'b1);
		end
		endcase
	endtask

	task automatic note_mismatch(input string what, input cache_rsp_t want, input cache_rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected kind %0d key %h value %h last %b, got kind %0d key %h value %h last %b",
				what, want.kind, want.key, want.value, want.last,
				got.kind, got.key, got.value, got.last);
	endtask

	// Monitor: predict accepted requests, check delivered results.
	always @(posedge clk) begin : watch_cache
		cache_rsp_t want, got;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lru_write_back_cache_core_tb failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_we)
				capacity_reg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				cache_access(s_tuser, s_tdata[31:0], s_tdata[63:32]);
				taken_count++;
			end
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.key = m_tdata[31:0];
				got.value = m_tdata[63:32];
				got.last = m_tlast;
				if (expected_responses.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_responses.pop_front();
					if (got.kind !== want.kind || got.key !== want.key ||
							got.value !== want.value || got.last !== want.last)
						note_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// Driver: bursts of requests with random gaps.
	always @(negedge clk) begin : drive_requests
		cache_req_t req;
		logic valid_next;
		valid_next = s_tvalid;
		if (arst_n && taken_count == offered_count) begin
			valid_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_requests.size() > 0) begin
				req = pending_requests.pop_front();
				if (reads_unwritten(req.op, req.key))
					req.op = OP_FILL;
				s_tdata <= {req.value, req.key};
				s_tuser <= req.op;
				valid_next = 1'b1;
				offered_count++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		s_tvalid <= valid_next;
	end

	// Result side: stretches of different stall patterns, plus one long hold.
	always @(negedge clk) begin : pace_results
		logic ready;
		if (stall_request && !stall_served) begin
			hold_left = 400;
			stall_served = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			ready = 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(10, 150);
			end
			rx_left--;
			case (rx_mode)
			0: ready = 1'b1;
			1: ready = $urandom_range(0, 1);
			2: ready = ($urandom_range(0, 3) == 0);
			default: ready = ($urandom_range(0, 7) != 0);
			endcase
		end
		m_tready <= ready;
	end

	task automatic queue_request(input logic [OP_W-1:0] op, input logic [31:0] key,
			input logic [31:0] value);
		cache_req_t req;
		req.op = op;
		req.key = key;
		req.value = value;
		pending_requests.push_back(req);
	endtask

	// Mostly get/fill pairs and sets over a small key pool, with stray fills and odd keys.
	task automatic queue_random_phase(input int active, input int count);
		logic [31:0] pool [12];
		logic [31:0] key;
		int pool_n, made, roll;
		pool_n = active + 3;
		for (int i = 0; i < pool_n; i++) begin
			pool[i] = $urandom;
			if (pool[i] == 0)
				pool[i] = 32'h1;
		end
		made = 0;
		while (made < count) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				key = '0;
			else if (roll == 1)
				key = $urandom;
			else
				key = pool[$urandom_range(0, pool_n - 1)];
			roll = $urandom_range(0, 19);
			if (roll < 7) begin
				queue_request(OP_SET, key, $urandom);
			end else if (roll < 16) begin
				queue_request(OP_GET, key, $urandom);
				if (roll < 14) begin
					queue_request(OP_FILL, $urandom, $urandom);
					made++;
				end
			end else if (roll < 18) begin
				queue_request(OP_FILL, $urandom, $urandom);
			end else begin
				queue_request(OP_FLUSH, key, $urandom);
			end
			made++;
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || taken_count != offered_count ||
				expected_responses.size() != 0)
			@(negedge clk);
	endtask

	initial begin : run_test
		int caps [8];
		caps = '{3, 0, 1, 15, 2, 5, 8, 4};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_request(OP_FLUSH, 32'h0, 32'h0);
		queue_request(OP_SET, 32'h1, 32'h0);
		queue_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OP_GET, 32'h1, 32'h0);
		queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
		// key zero goes straight to the backing store
		queue_request(OP_GET, 32'h0, 32'h0);
		queue_request(OP_FILL, 32'h0, 32'hA5A5_A5A5);
		queue_request(OP_FILL, 32'h0, 32'h5A5A_5A5A);
		queue_request(OP_SET, 32'h0, 32'h1234_5678);
		queue_request(OP_GET, 32'h100, 32'h0);
		queue_request(OP_FILL, 32'h0, 32'hCAFE_F00D);
		queue_request(OP_GET, 32'h100, 32'h0);
		// second miss replaces the outstanding one
		queue_request(OP_GET, 32'h200, 32'h0);
		queue_request(OP_GET, 32'h300, 32'h0);
		queue_request(OP_FILL, 32'h0, 32'h0BAD_BEEF);
		queue_request(OP_GET, 32'h300, 32'h0);
		queue_request(OP_SET, 32'h200, 32'h77);
		queue_request(OP_SET, 32'h400, 32'h4);
		queue_request(OP_SET, 32'h500, 32'h5);
		queue_request(OP_SET, 32'h600, 32'h6);
		// full: evict dirty LRU entries
		queue_request(OP_SET, 32'h700, 32'h7);
		queue_request(OP_GET, 32'h800, 32'h0);
		queue_request(OP_SET, 32'h800, 32'h8);
		queue_request(OP_FLUSH, 32'h0, 32'h0);
		// fetched value dropped: slot went dirty meanwhile
		queue_request(OP_FILL, 32'h0, 32'h3);

		foreach (caps[p]) begin
			wait_drained();
			repeat (SETTLE) @(negedge clk);
			cfg_wdata = CFG_W'(caps[p]);
			cfg_we = 1'b1;
			@(negedge clk);
			cfg_we = 1'b0;
			if (p == 3)
				stall_request = 1'b1;
			queue_random_phase((caps[p] > CACHE_SLOTS) ? CACHE_SLOTS : caps[p], 56);
		end

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatch_count == 0 && expected_responses.size() == 0)
			$display("lru_write_back_cache_core_tb passed");
		else
			$display("lru_write_back_cache_core_tb failed");
		$finish;
	end

endmodule
